// File: sv/dpfl_pkg.sv
// Package for the dated price floor lookup: word types, sizes and status codes.
`default_nettype none
package dpfl_pkg;
    localparam int TABLE_DEPTH = 2048;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 23;
    localparam int PRICE_W     = 40;
    localparam int PROD_W      = 50;
    localparam int AMT_W       = 26;

    localparam logic [31:0] AMOUNT_MAX_RAW = 32'd65536000;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_MON  = 3'd1;
    localparam logic [2:0] ST_BAD_DAY  = 3'd2;
    localparam logic [2:0] ST_DAY_31   = 3'd3;
    localparam logic [2:0] ST_AMOUNT   = 3'd4;
    localparam logic [2:0] ST_NO_PRICE = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [13:0]        year;
        logic [6:0]         month;
        logic [6:0]         day;
        logic [39:0]        price;
        logic signed [31:0] amount;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [49:0] product;
    } out_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
    } entry_t;
endpackage
`default_nettype wire

// File: sv/dated_price_floor_lookup.sv
// Sorted dated price table with binary-search floor lookup, one entry memory.
// A query runs a binary search over the registered-read entry memory, one price read
// when no entry matches exactly, and two multiply steps; a load runs the search and
// then shifts the entries above its place up by one when it is inserted out of order.
// One word is in work at a time; the next is taken once the result has been accepted.
// Reset (aresetn low, synchronous) empties the table; entries are not cleared.
`default_nettype none
module dated_price_floor_lookup import dpfl_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_word_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_word_t      m_data
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_SHR  = 4'd4;
    localparam logic [3:0] S_SHW  = 4'd5;
    localparam logic [3:0] S_PRD  = 4'd6;
    localparam logic [3:0] S_PWT  = 4'd7;
    localparam logic [3:0] S_M1   = 4'd8;
    localparam logic [3:0] S_M2   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [COUNT_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    in_word_t           req_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [2:0]         dstat_reg;
    logic [2:0]         status_reg, status_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PRICE_W-1:0] price_reg, price_next;

    entry_t             mem [TABLE_DEPTH];
    entry_t             q_reg;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic               wr_en;
    entry_t             wr_data;

    logic [COUNT_W:0]   mid_sum;
    logic               match;
    logic [AMT_W-1:0]   amt;

    // date check in the fixed priority order
    function automatic logic [2:0] check_date(logic [6:0] m, logic [6:0] d);
        logic [2:0] r;
        r = ST_OK;
        if (m < 7'd1 || m > 7'd12) r = ST_BAD_MON;
        else if (d < 7'd1 || d > 7'd31) r = ST_BAD_DAY;
        else if (m == 7'd2 && d > 7'd29) r = ST_BAD_DAY;
        else if ((m == 7'd4 || m == 7'd6 || m == 7'd9 || m == 7'd11) && d > 7'd30)
            r = ST_DAY_31;
        return r;
    endfunction

    // key from saturated month and day
    function automatic logic [KEY_W-1:0] make_key(logic [13:0] y, logic [6:0] m,
                                                  logic [6:0] d);
        logic [3:0] ms;
        logic [4:0] ds;
        ms = (m > 7'd15) ? 4'd15 : m[3:0];
        ds = (d > 7'd31) ? 5'd31 : d[4:0];
        return {y, ms, ds};
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = '{status: status_reg, product: prod_reg};

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign match   = (lo_reg < count_reg) && (q_reg.key == key_reg);
    assign amt     = req_reg.amount[AMT_W-1:0];

    // entry memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        q_reg <= mem[rd_addr];
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        i_next      = i_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        prod_next   = prod_reg;
        price_next  = price_reg;
        rd_addr     = lo_reg[ADDR_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = lo_reg[ADDR_W-1:0];
        wr_data     = '{key: key_reg, price: req_reg.price};
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    lo_next    = '0;
                    hi_next    = count_reg;
                    prod_next  = '0;
                    state_next = S_SRCH;
                end
            end
            S_SRCH: begin
                if (lo_reg < hi_reg) begin
                    mid_next   = mid_sum[COUNT_W:1];
                    rd_addr    = mid_sum[ADDR_W:1];
                    state_next = S_CMP;
                end else begin
                    state_next = S_CHK;
                end
            end
            S_CMP: begin
                if (q_reg.key < key_reg) lo_next = mid_reg + 1'b1;
                else hi_next = mid_reg;
                state_next = S_SRCH;
            end
            S_CHK: begin
                if (req_reg.req_type == REQ_LOAD) begin
                    status_next = dstat_reg;
                    if (match) begin
                        wr_en      = 1'b1;
                        state_next = S_OUT;
                    end else if (count_reg >= COUNT_W'(TABLE_DEPTH)) begin
                        status_next = ST_FULL;
                        state_next  = S_OUT;
                    end else begin
                        i_next     = count_reg;
                        state_next = S_SHR;
                    end
                end else begin
                    if (dstat_reg != ST_OK) begin
                        status_next = dstat_reg;
                        state_next  = S_OUT;
                    end else if (req_reg.amount > AMOUNT_MAX_RAW) begin
                        status_next = ST_AMOUNT;
                        state_next  = S_OUT;
                    end else if (match) begin
                        status_next = ST_OK;
                        price_next  = q_reg.price;
                        state_next  = S_M1;
                    end else if (lo_reg != '0) begin
                        status_next = ST_OK;
                        idx_next    = ADDR_W'(lo_reg - 1'b1);
                        state_next  = S_PRD;
                    end else begin
                        status_next = ST_NO_PRICE;
                        state_next  = S_OUT;
                    end
                end
            end
            S_SHR: begin
                if (i_reg > lo_reg) begin
                    rd_addr    = ADDR_W'(i_reg - 1'b1);
                    state_next = S_SHW;
                end else begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_OUT;
                end
            end
            S_SHW: begin
                wr_en      = 1'b1;
                wr_addr    = i_reg[ADDR_W-1:0];
                wr_data    = q_reg;
                i_next     = i_reg - 1'b1;
                state_next = S_SHR;
            end
            S_PRD: begin
                rd_addr    = idx_reg;
                state_next = S_PWT;
            end
            S_PWT: begin
                price_next = q_reg.price;
                state_next = S_M1;
            end
            S_M1: begin
                prod_next  = PROD_W'(amt) * PROD_W'(price_reg[PRICE_W-1:16]);
                state_next = S_M2;
            end
            S_M2: begin
                prod_next  = prod_reg + ((PROD_W'(amt) * PROD_W'(price_reg[15:0])) >> 16);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        i_reg      <= i_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        prod_reg   <= prod_next;
        price_reg  <= price_next;
        if (s_valid && s_ready) begin
            req_reg   <= s_data;
            key_reg   <= make_key(s_data.year, s_data.month, s_data.day);
            dstat_reg <= check_date(s_data.month, s_data.day);
        end
    end

    // checks
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(TABLE_DEPTH)) else $error("entry count overflow");
    a_prod_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && status_reg != ST_OK) |-> (prod_reg == '0))
        else $error("nonzero product with error status");
    a_search_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHK) |-> (lo_reg == hi_reg && lo_reg <= count_reg))
        else $error("search bounds broken");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_SHR))
        else $error("count changed outside insert");
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for the dated price floor lookup: directed table plus random loads and queries.
`default_nettype none
module tb_top;
    import dpfl_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    dated_price_floor_lookup u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Shadow copy of the sorted price table
    logic [KEY_W-1:0]   shadow_keys [TABLE_DEPTH];
    logic [PRICE_W-1:0] shadow_prices [TABLE_DEPTH];
    int                 shadow_count;

    out_word_t answer_q [$];
    int        mismatch_count;
    int        cycle_count;
    bit        timed_out;
    bit        stim_done;

    localparam int CYCLE_LIMIT = 20000000;

    function automatic logic [2:0] date_status(logic [6:0] mon, logic [6:0] dd);
        if (mon < 1 || mon > 12) return ST_BAD_MON;
        if (dd < 1 || dd > 31) return ST_BAD_DAY;
        if (mon == 2 && dd > 29) return ST_BAD_DAY;
        if ((mon == 4 || mon == 6 || mon == 9 || mon == 11) && dd > 30) return ST_DAY_31;
        return ST_OK;
    endfunction

    function automatic logic [KEY_W-1:0] date_key(in_word_t w);
        logic [3:0] m;
        logic [4:0] d;
        m = (w.month > 15) ? 4'd15 : w.month[3:0];
        d = (w.day > 31) ? 5'd31 : w.day[4:0];
        return {w.year, m, d};
    endfunction

    // Entries strictly below the key (table is sorted)
    function automatic int rank_below(logic [KEY_W-1:0] k);
        int lo, hi, mid;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] < k) lo = mid + 1;
            else hi = mid;
        end
        return lo;
    endfunction

    // Applies one word to the shadow table and returns its answer
    function automatic out_word_t price_floor_answer(in_word_t w);
        out_word_t       r;
        logic [2:0]      ds;
        logic [KEY_W-1:0] k;
        int              pos, idx;
        logic [63:0]     a, p, prod;
        ds = date_status(w.month, w.day);
        k = date_key(w);
        pos = rank_below(k);
        r.product = '0;
        if (w.req_type == REQ_LOAD) begin
            r.status = ds;
            if (pos < shadow_count && shadow_keys[pos] == k) begin
                shadow_prices[pos] = w.price;
            end else if (shadow_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_keys[i] = shadow_keys[i-1];
                    shadow_prices[i] = shadow_prices[i-1];
                end
                shadow_keys[pos] = k;
                shadow_prices[pos] = w.price;
                shadow_count++;
            end
        end else if (ds != ST_OK) begin
            r.status = ds;
        end else if ($unsigned(w.amount) > AMOUNT_MAX_RAW) begin
            r.status = ST_AMOUNT;
        end else begin
            idx = -1;
            if (pos < shadow_count && shadow_keys[pos] == k) idx = pos;
            else if (pos > 0) idx = pos - 1;
            if (idx < 0) begin
                r.status = ST_NO_PRICE;
            end else begin
                a = {32'd0, w.amount};
                p = {24'd0, shadow_prices[idx]};
                prod = a * (p >> 16) + ((a * (p & 64'hFFFF)) >> 16);
                r.product = prod[49:0];
                r.status = ST_OK;
            end
        end
        return r;
    endfunction

    function automatic in_word_t make_word(logic rt, int yr, int mon, int dd,
                                           logic [39:0] pr, logic [31:0] amt);
        in_word_t w;
        w.req_type = rt;
        w.year = 14'(yr);
        w.month = 7'(mon);
        w.day = 7'(dd);
        w.price = pr;
        w.amount = amt;
        return w;
    endfunction

    // Random word; mostly valid dates near a small set of years to hit matches
    function automatic in_word_t random_word();
        in_word_t w;
        int       r;
        w = make_word(1'($urandom_range(0, 1)), 0, 0, 0, '0, '0);
        r = $urandom_range(0, 99);
        if (r < 10) w.year = 14'($urandom_range(0, 16383));
        else w.year = 14'(2000 + $urandom_range(0, 7));
        if (r < 85) begin
            w.month = 7'($urandom_range(1, 12));
            w.day = 7'($urandom_range(1, 31));
            if (w.month == 2 && w.day > 29) w.day = 7'($urandom_range(1, 29));
        end else begin
            w.month = 7'($urandom_range(0, 127));
            w.day = 7'($urandom_range(0, 127));
        end
        w.price = 40'({$urandom(), $urandom()});
        r = $urandom_range(0, 9);
        if (r < 7) w.amount = $urandom_range(0, 65536000);
        else if (r < 8) w.amount = 65536000 + $urandom_range(0, 2);
        else w.amount = $urandom();
        return w;
    endfunction

    // Valid is dropped after each word and stays low for a random gap before the next one
    task automatic send_word(in_word_t w);
        out_word_t r;
        int        gap;
        gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 30);
        if ($urandom_range(0, 3) == 0) gap = 1;
        repeat (gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = price_floor_answer(w);
        answer_q.push_back(r);
        s_valid <= 1'b0;
    endtask

    // Directed rows; check_fixed marks a hand-typed expectation
    typedef struct {
        in_word_t  word;
        bit        check_fixed;
        out_word_t fixed;
    } stim_row_t;

    stim_row_t directed_rows [$];

    task automatic add_row(in_word_t w, bit fx, logic [2:0] st, logic [49:0] pd);
        stim_row_t row;
        row.word = w;
        row.check_fixed = fx;
        row.fixed.status = st;
        row.fixed.product = pd;
        directed_rows.push_back(row);
    endtask

    // Stimulus
    initial begin
        in_word_t  w;
        out_word_t pr;
        int        wait_cycles;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        stim_done = 1'b0;
        shadow_count = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table, date checks, extremes
        add_row(make_word(REQ_QUERY, 2000, 5, 5, 0, 32'h10000), 1, ST_NO_PRICE, 0);
        add_row(make_word(REQ_QUERY, 2000, 0, 5, 0, 0), 1, ST_BAD_MON, 0);
        add_row(make_word(REQ_QUERY, 2000, 13, 5, 0, 0), 1, ST_BAD_MON, 0);
        add_row(make_word(REQ_QUERY, 2000, 3, 0, 0, 0), 1, ST_BAD_DAY, 0);
        add_row(make_word(REQ_QUERY, 2000, 3, 32, 0, 0), 1, ST_BAD_DAY, 0);
        add_row(make_word(REQ_QUERY, 2000, 2, 30, 0, 0), 1, ST_BAD_DAY, 0);
        add_row(make_word(REQ_QUERY, 2000, 4, 31, 0, 0), 1, ST_DAY_31, 0);
        add_row(make_word(REQ_QUERY, 2000, 11, 31, 0, 0), 1, ST_DAY_31, 0);
        add_row(make_word(REQ_QUERY, 2000, 5, 5, 0, 32'hFFFFFFFF), 1, ST_AMOUNT, 0);
        add_row(make_word(REQ_QUERY, 2000, 5, 5, 0, 65536001), 1, ST_AMOUNT, 0);
        // Loads, including bad dates that still insert
        add_row(make_word(REQ_LOAD, 2000, 1, 1, 40'h10000, 0), 1, ST_OK, 0);
        add_row(make_word(REQ_LOAD, 2010, 6, 15, 40'hFF_FFFF_FFFF, 32'hFFFFFFFF),
                1, ST_OK, 0);
        add_row(make_word(REQ_LOAD, 2005, 99, 99, 40'h30000, 0), 1, ST_BAD_MON, 0);
        add_row(make_word(REQ_LOAD, 0, 1, 1, 40'h20000, 0), 1, ST_OK, 0);
        add_row(make_word(REQ_LOAD, 16383, 12, 31, 40'h50000, 0), 1, ST_OK, 0);
        add_row(make_word(REQ_LOAD, 2000, 1, 1, 40'h18000, 0), 1, ST_OK, 0);
        // Exact first entry, between entries, after last, max products
        add_row(make_word(REQ_QUERY, 0, 1, 1, 0, 32'h10000), 1, ST_OK, 50'h20000);
        add_row(make_word(REQ_QUERY, 2000, 1, 1, 0, 32'h20000), 1, ST_OK, 50'h30000);
        add_row(make_word(REQ_QUERY, 2003, 7, 4, 0, 32'h10000), 0, 0, 0);
        add_row(make_word(REQ_QUERY, 2010, 6, 15, 0, 65536000), 0, 0, 0);
        add_row(make_word(REQ_QUERY, 2010, 6, 15, 0, 0), 1, ST_OK, 0);
        add_row(make_word(REQ_QUERY, 16383, 12, 31, 0, 65536000), 0, 0, 0);
        add_row(make_word(REQ_QUERY, 9999, 2, 29, 0, 32'h8001), 0, 0, 0);

        foreach (directed_rows[i]) begin
            w = directed_rows[i].word;
            send_word(w);
            if (directed_rows[i].check_fixed) begin
                pr = answer_q[$];
                if (pr != directed_rows[i].fixed) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("directed row %0d: predicted %h, table says %h",
                                 i, pr, directed_rows[i].fixed);
                end
            end
        end

        // Hold off until every answer has drained
        while (answer_q.size() != 0) @(posedge aclk);

        for (int n = 0; n < 1300; n++) begin
            send_word(random_word());
            if (n == 600) while (answer_q.size() != 0) @(posedge aclk);
        end
        stim_done = 1'b1;
    end

    // Result side: random stalls and checking
    initial begin
        out_word_t exp_w;
        m_ready = 1'b0;
        mismatch_count = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (answer_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: status %0d product %h",
                                 m_data.status, m_data.product);
                end else begin
                    exp_w = answer_q.pop_front();
                    if (m_data.status !== exp_w.status || m_data.product !== exp_w.product) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected status %0d product %h, got %0d %h",
                                     exp_w.status, exp_w.product,
                                     m_data.status, m_data.product);
                    end
                end
            end
            if ($urandom_range(0, 9) < 7) m_ready <= 1'b1;
            else if ($urandom_range(0, 9) == 0) m_ready <= 1'b0;
            else m_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog and end of run
    initial begin
        cycle_count = 0;
        timed_out = 1'b0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                timed_out = 1'b1;
                $display("Verification failed");
                $finish;
            end
            if (stim_done && answer_q.size() == 0) begin
                repeat (200) begin
                    @(posedge aclk);
                    if (m_valid) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("extra word after drain: status %0d", m_data.status);
                    end
                end
                if (mismatch_count == 0)
                    $display("Verification passed");
                else
                    $display("Verification failed");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire

// File: sim.f
sv/dpfl_pkg.sv
sv/dated_price_floor_lookup.sv
tb/tb_top.sv
